@@ sv/pbfs_pkg.sv @@
// ============================================================================
// Protobuf field scanner package
// Shared record types, status codes and sizing constants for the scanner.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pbfs_pkg;

    // Parse status codes carried in every record.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_BAD_WTYPE = 2'd2;
    localparam logic [1:0] ST_LONG_VINT = 2'd3;

    // Record kinds.
    localparam logic KIND_FIELD   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Wire types that the scanner accepts.
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // A varint has at most ten bytes; the tenth byte has digit index nine.
    localparam logic [3:0] DIGIT_LAST = 4'd9;

    // Depth of the result queue and the packed width of the result data.
    localparam int unsigned OUT_DEPTH   = 4;
    localparam int unsigned OUT_TDATA_W = 136;

    typedef struct packed {
        logic        kind;
        logic [31:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] varint_value;
        logic [15:0] payload_offset;
        logic [16:0] payload_length;
        logic [1:0]  parse_status;
        logic        all_fields_match;
        logic        final_record;
    } t_record;

    localparam t_record REC_ZERO = '0;

    // Results of one byte: an optional field or error record, then an
    // optional verdict.
    typedef struct packed {
        logic    push0;
        t_record rec0;
        logic    push1;
        t_record rec1;
    } t_result_set;

    typedef enum logic [4:0] {
        PH_KEY   = 5'b00001,
        PH_VALUE = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_SKIP  = 5'b01000,
        PH_DRAIN = 5'b10000
    } t_phase;

endpackage

`default_nettype wire

@@ sv/protobuf_field_scanner_core.sv @@
// ============================================================================
// Protobuf field scanner core
// Byte-stream parser for protobuf wire format with per-buffer verdict.
// ============================================================================
// The scanner takes one byte of an encoded buffer per request and reports
// every completed field as a record: field number, wire type, the decoded
// value of a varint field, or the offset and length of a fixed64, fixed32 or
// length-delimited payload, which is skipped. A varint longer than ten bytes,
// an unsupported wire type, a length larger than MAX_BUFFER_BYTES or a
// buffer that ends inside a field yields an error record, and the rest of
// that buffer is ignored. The last byte of a buffer (marked by tlast) also
// yields a verdict record that says whether at least one field was seen,
// every field was length-delimited with the configured field number and no
// error occurred. A byte is registered, parsed from that register and its
// records enter a four-entry result queue, so a new byte is taken in every
// cycle as long as the queue has room for two records. An accepted byte's
// records reach the output through the input register and the result queue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module protobuf_field_scanner_core #(
    parameter int unsigned MAX_BUFFER_BYTES = 65536
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Expected field number for the verdict.
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [31:0]                       i_cfg_wr_data,
    // Byte stream in.
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,   // data_byte
    input  wire logic                              s_axis_tlast,   // end_of_buffer
    // Records out.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // field_number[31:0], wire_type[34:32], varint_value[98:35],
    // payload_offset[114:99], payload_length[131:115], parse_status[133:132],
    // all_fields_match[134], zero pad[135]
    output logic [pbfs_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic                                   m_axis_tuser,   // record_kind
    output logic                                   m_axis_tlast    // final_record
);
    import pbfs_pkg::*;

    t_result_set w_results;
    logic        w_room;
    t_record     w_rec;

    // Parser: input register, parse state and record building.
    pbfs_parser #(
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_in_byte     (s_axis_tdata),
        .i_in_eob      (s_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_room    (w_room),
        .o_results     (w_results)
    );

    // Result queue: decouples the parser from output back-pressure and
    // absorbs the extra verdict record at the end of a buffer.
    pbfs_out_fifo u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_results (w_results),
        .o_room    (w_room),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_rec     (w_rec)
    );

    assign m_axis_tdata = {1'b0, w_rec.all_fields_match, w_rec.parse_status,
                           w_rec.payload_length, w_rec.payload_offset,
                           w_rec.varint_value, w_rec.wire_type, w_rec.field_number};
    assign m_axis_tuser = w_rec.kind;
    assign m_axis_tlast = w_rec.final_record;

    // A verdict is always the last record caused by its byte.
    a_verdict_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_VERDICT) |-> m_axis_tlast)
        else $error("verdict record not marked final");

    // A positive verdict can only come from a buffer without errors.
    a_match_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_VERDICT && m_axis_tdata[134])
        |-> (m_axis_tdata[133:132] == ST_OK))
        else $error("positive verdict with error status");

    // Field records and error records never claim a match.
    a_field_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_FIELD) |-> !m_axis_tdata[134])
        else $error("match flag set in a field record");

    // The input stalls only while results are waiting at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

endmodule

`default_nettype wire

@@ sv/pbfs_parser.sv @@
// ============================================================================
// Protobuf field scanner parser
// Input register, per-byte parse state and the record building logic.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pbfs_parser #(
    parameter int unsigned MAX_BUFFER_BYTES = 65536
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_in_byte,
    input  wire logic                 i_in_eob,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [31:0]          i_cfg_wr_data,
    input  wire logic                 i_out_room,
    output pbfs_pkg::t_result_set     o_results
);
    import pbfs_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_BUFFER_BYTES + 1);

    // Input register.
    logic             r_in_vld;
    logic [7:0]       r_in_byte;
    logic             r_in_eob;

    // Parse state.
    logic [31:0]      r_expected;
    t_phase           r_phase,   n_phase;
    logic [63:0]      r_acc,     n_acc;
    logic [3:0]       r_cnt,     n_cnt;
    logic [POS_W-1:0] r_pos,     n_pos;
    logic [31:0]      r_fn,      n_fn;
    logic [2:0]       r_wt,      n_wt;
    logic [POS_W-1:0] r_skip,    n_skip;
    logic [15:0]      r_pstart,  n_pstart;
    logic [POS_W-1:0] r_psize,   n_psize;
    logic             r_seen,    n_seen;
    logic             r_match,   n_match;
    logic [1:0]       r_err,     n_err;

    logic             w_adv;
    logic [6:0]       w_shamt;
    logic [63:0]      w_acc_new;
    logic [31:0]      w_pos_inc;
    logic [31:0]      w_psize_ext;
    logic [POS_W-1:0] w_dec;
    logic             w_fin;
    logic [63:0]      w_fin_val;
    logic [15:0]      w_fin_off;
    logic [16:0]      w_fin_len;
    logic             w_raise;
    logic [1:0]       w_raise_code;
    logic             w_v0, w_v1;
    t_record          w_r0, w_r1;

    assign w_adv      = r_in_vld && i_out_room;
    assign o_in_ready = !r_in_vld || w_adv;

    assign w_shamt     = 7'(r_cnt) * 7'd7;
    assign w_acc_new   = r_acc | (64'(r_in_byte[6:0]) << w_shamt);
    assign w_pos_inc   = 32'(r_pos) + 32'd1;
    assign w_psize_ext = 32'(r_psize);
    assign w_dec       = (r_skip != '0) ? r_skip - POS_W'(1) : '0;

    always_comb begin
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_cnt        = r_cnt;
        n_fn         = r_fn;
        n_wt         = r_wt;
        n_skip       = r_skip;
        n_pstart     = r_pstart;
        n_psize      = r_psize;
        n_seen       = r_seen;
        n_match      = r_match;
        n_err        = r_err;
        n_pos        = (r_pos < POS_W'(MAX_BUFFER_BYTES)) ? r_pos + POS_W'(1) : r_pos;
        w_fin        = 1'b0;
        w_fin_val    = '0;
        w_fin_off    = '0;
        w_fin_len    = '0;
        w_raise      = 1'b0;
        w_raise_code = ST_OK;
        w_v0         = 1'b0;
        w_v1         = 1'b0;
        w_r0         = REC_ZERO;
        w_r1         = REC_ZERO;

        case (r_phase)
            PH_KEY, PH_VALUE, PH_LEN: begin
                if (r_in_byte[7]) begin
                    if (r_cnt == DIGIT_LAST) begin
                        w_raise      = 1'b1;
                        w_raise_code = ST_LONG_VINT;
                    end else begin
                        n_acc = w_acc_new;
                        n_cnt = r_cnt + 4'd1;
                    end
                end else begin
                    n_acc = '0;
                    n_cnt = '0;
                    if (r_phase == PH_KEY) begin
                        n_fn = w_acc_new[34:3];
                        n_wt = w_acc_new[2:0];
                        case (w_acc_new[2:0])
                            WT_VARINT: n_phase = PH_VALUE;
                            WT_LEN:    n_phase = PH_LEN;
                            WT_FIXED64, WT_FIXED32: begin
                                n_skip   = (w_acc_new[2:0] == WT_FIXED64) ?
                                           POS_W'(8) : POS_W'(4);
                                n_psize  = n_skip;
                                n_pstart = w_pos_inc[15:0];
                                n_phase  = PH_SKIP;
                            end
                            default: begin
                                w_raise      = 1'b1;
                                w_raise_code = ST_BAD_WTYPE;
                            end
                        endcase
                    end else if (r_phase == PH_VALUE) begin
                        w_fin     = 1'b1;
                        w_fin_val = w_acc_new;
                    end else if (w_acc_new > 64'(MAX_BUFFER_BYTES)) begin
                        // A length that no buffer can hold is a truncation.
                        w_raise      = 1'b1;
                        w_raise_code = ST_TRUNCATED;
                    end else if (w_acc_new == 64'd0) begin
                        w_fin     = 1'b1;
                        w_fin_off = w_pos_inc[15:0];
                    end else begin
                        n_skip   = w_acc_new[POS_W-1:0];
                        n_psize  = w_acc_new[POS_W-1:0];
                        n_pstart = w_pos_inc[15:0];
                        n_phase  = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                n_skip = w_dec;
                if (w_dec == '0) begin
                    w_fin     = 1'b1;
                    w_fin_off = r_pstart;
                    w_fin_len = w_psize_ext[16:0];
                end
            end
            default: ;
        endcase

        if (w_fin) begin
            w_v0                = 1'b1;
            w_r0.kind           = KIND_FIELD;
            w_r0.field_number   = r_fn;
            w_r0.wire_type      = r_wt;
            w_r0.varint_value   = w_fin_val;
            w_r0.payload_offset = w_fin_off;
            w_r0.payload_length = w_fin_len;
            n_seen              = 1'b1;
            if (r_fn != r_expected || r_wt != WT_LEN) begin
                n_match = 1'b0;
            end
            n_fn    = '0;
            n_wt    = '0;
            n_phase = PH_KEY;
        end

        if (w_raise) begin
            w_v0              = 1'b1;
            w_r0.field_number = n_fn;
            w_r0.wire_type    = n_wt;
            w_r0.parse_status = w_raise_code;
            n_err             = w_raise_code;
            n_phase           = PH_DRAIN;
        end

        if (r_in_eob) begin
            if (n_phase != PH_DRAIN && !(n_phase == PH_KEY && n_cnt == '0)) begin
                w_v0              = 1'b1;
                w_r0.field_number = n_fn;
                w_r0.wire_type    = n_wt;
                w_r0.parse_status = ST_TRUNCATED;
                n_err             = ST_TRUNCATED;
            end
            w_v1                  = 1'b1;
            w_r1.kind             = KIND_VERDICT;
            w_r1.parse_status     = n_err;
            w_r1.all_fields_match = n_seen && n_match && (n_err == ST_OK);
            w_r1.final_record     = 1'b1;
            // Start the next buffer from a clean slate.
            n_phase  = PH_KEY;
            n_acc    = '0;
            n_cnt    = '0;
            n_pos    = '0;
            n_fn     = '0;
            n_wt     = '0;
            n_skip   = '0;
            n_pstart = '0;
            n_psize  = '0;
            n_seen   = 1'b0;
            n_match  = 1'b1;
            n_err    = ST_OK;
        end else begin
            w_r0.final_record = 1'b1;
        end
    end

    always_comb begin
        o_results.push0 = w_adv && w_v0;
        o_results.rec0  = w_r0;
        o_results.push1 = w_adv && w_v1;
        o_results.rec1  = w_r1;
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_eob  <= i_in_eob;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_expected <= '0;
            r_phase    <= PH_KEY;
            r_acc      <= '0;
            r_cnt      <= '0;
            r_pos      <= '0;
            r_fn       <= '0;
            r_wt       <= '0;
            r_skip     <= '0;
            r_pstart   <= '0;
            r_psize    <= '0;
            r_seen     <= 1'b0;
            r_match    <= 1'b1;
            r_err      <= ST_OK;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_expected <= i_cfg_wr_data;
            end
            if (w_adv) begin
                r_phase  <= n_phase;
                r_acc    <= n_acc;
                r_cnt    <= n_cnt;
                r_pos    <= n_pos;
                r_fn     <= n_fn;
                r_wt     <= n_wt;
                r_skip   <= n_skip;
                r_pstart <= n_pstart;
                r_psize  <= n_psize;
                r_seen   <= n_seen;
                r_match  <= n_match;
                r_err    <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/pbfs_out_fifo.sv @@
// ============================================================================
// Protobuf field scanner result queue
// Small queue that takes up to two records a cycle and hands out one.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pbfs_out_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire pbfs_pkg::t_result_set i_results,
    output logic                       o_room,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output pbfs_pkg::t_record          o_rec
);
    import pbfs_pkg::*;

    localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
    localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

    t_record           r_mem [OUT_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]  w_wr_ptr1;
    logic              w_pop;

    assign o_valid   = (r_count != '0);
    assign o_rec     = r_mem[r_rd_ptr];
    assign w_pop     = o_valid && i_ready;
    // The parser only moves on when a whole pair of records fits.
    assign o_room    = (r_count <= CNT_W'(OUT_DEPTH - 2));
    assign w_wr_ptr1 = i_results.push0 ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;

    always_comb begin
        n_wr_ptr = w_wr_ptr1;
        if (i_results.push1) begin
            n_wr_ptr = w_wr_ptr1 + PTR_W'(1);
        end
        n_count = r_count + CNT_W'(i_results.push0) + CNT_W'(i_results.push1)
                  - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_results.push0) begin
            r_mem[r_wr_ptr] <= i_results.rec0;
        end
        if (i_results.push1) begin
            r_mem[w_wr_ptr1] <= i_results.rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire
